// ===== rtl/srb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_pkg: shared types for the sequence reorder buffer
// Controller states, the command and status structs between the controller
// and the datapath, and the result status codes.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int unsigned SEQ_W = 32;
    localparam int unsigned TAG_W = 16;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_STALE  = 2'd1,
        ST_DUP    = 2'd2,
        ST_BEYOND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DRAIN
    } t_state;

    // outcome of classifying the captured word
    typedef enum logic [1:0] {
        CLS_INORDER,
        CLS_PARK,
        CLS_ERROR
    } t_cls;

    typedef struct packed {
        logic cap;        // capture the input word
        logic emit_err;   // emit one error result
        logic park;       // store the tag in its window slot
        logic rel_first;  // release the arriving word
        logic rel_drain;  // release the parked word at the head
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic more;       // slot after the head holds a parked word
    } t_stat;

endpackage

// ===== rtl/sequence_reorder_buffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_top: per-direction sequence number reorder buffer
// Releases segments in sequence order, parks early ones in a circular window.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: a word (direction, seq_no, tag) is taken at a clock edge with
//    start high and busy low. Hold start only while a word is offered.
//  - Output: each result word is on the o_ ports for one cycle, marked by
//    o_strobe. The receiver cannot stall; it must take every strobe.
//  - An in-order segment gives a release word and then one release word per
//    parked segment that follows without a gap; o_last marks the final one.
//    An early segment inside the window is parked and gives no word. Stale,
//    duplicate and out-of-window segments give one error word.
//  - Flow: accept moves the controller to check; the first result word is
//    registered at the end of check. Busy stays high through check and drain,
//    so no segment is taken mid-run; the drain walks one slot per cycle.
//  - Config: writing i_cfg_wdata with i_cfg_we loads the first expected
//    number into every context, resets the window heads and drops all parked
//    segments. Write only while busy is low and no result is pending.
//  - Reset: synchronous, active low; same as a config write of zero.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_top #(
    parameter int unsigned WINDOW   = 16,
    parameter int unsigned CONTEXTS = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [srb_pkg::SEQ_W-1:0] i_cfg_wdata,
    input  logic                      i_direction,
    input  logic [srb_pkg::SEQ_W-1:0] i_seq_no,
    input  logic [srb_pkg::TAG_W-1:0] i_tag,
    output logic                      o_strobe,
    output logic                      o_released,
    output logic [srb_pkg::TAG_W-1:0] o_out_tag,
    output logic [srb_pkg::SEQ_W-1:0] o_out_seq_no,
    output logic                      o_last,
    output logic [1:0]                o_status
);

    srb_pkg::t_cmd  cmd;
    srb_pkg::t_stat stat;

    // controller: idle -> check -> (drain)* -> idle
    srb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: window state, tag store and result register
    srb_dpath #(
        .WINDOW   (WINDOW),
        .CONTEXTS (CONTEXTS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_direction  (i_direction),
        .i_seq_no     (i_seq_no),
        .i_tag        (i_tag),
        .o_strobe     (o_strobe),
        .o_released   (o_released),
        .o_out_tag    (o_out_tag),
        .o_out_seq_no (o_out_seq_no),
        .o_last       (o_last),
        .o_status     (o_status)
    );

endmodule

// ===== rtl/srb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_ctrl: reorder buffer controller
// Sequences capture, classification and the drain of parked words.
// ----------------------------------------------------------------------------
module srb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  srb_pkg::t_stat  i_stat,
    output srb_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    srb_pkg::t_state r_state;
    srb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srb_pkg::S_IDLE: begin
                if (i_start) n_state = srb_pkg::S_CHECK;
            end
            srb_pkg::S_CHECK: begin
                if (i_stat.cls == srb_pkg::CLS_INORDER && i_stat.more)
                    n_state = srb_pkg::S_DRAIN;
                else
                    n_state = srb_pkg::S_IDLE;
            end
            srb_pkg::S_DRAIN: begin
                if (!i_stat.more) n_state = srb_pkg::S_IDLE;
            end
            default: n_state = srb_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            srb_pkg::S_IDLE: begin
                o_cmd.cap = i_start;
            end
            srb_pkg::S_CHECK: begin
                unique case (i_stat.cls)
                    srb_pkg::CLS_INORDER: o_cmd.rel_first = 1'b1;
                    srb_pkg::CLS_PARK:    o_cmd.park      = 1'b1;
                    default:              o_cmd.emit_err  = 1'b1;
                endcase
            end
            srb_pkg::S_DRAIN: begin
                o_cmd.rel_drain = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != srb_pkg::S_IDLE);

    // drain is reached only through a check or a running drain
    a_drain_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srb_pkg::S_DRAIN) && $past(i_rst_n) |->
        ($past(r_state) == srb_pkg::S_CHECK || $past(r_state) == srb_pkg::S_DRAIN))
        else $error("drain entered from idle");

endmodule

// ===== rtl/srb_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_dpath: reorder buffer datapath
// Per-context expected number and window head, parked valid bits, the tag
// store and the registered result word.
// ----------------------------------------------------------------------------
module srb_dpath #(
    parameter int unsigned WINDOW   = 16,
    parameter int unsigned CONTEXTS = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  srb_pkg::t_cmd             i_cmd,
    output srb_pkg::t_stat            o_stat,
    input  logic                      i_cfg_we,
    input  logic [srb_pkg::SEQ_W-1:0] i_cfg_wdata,
    input  logic                      i_direction,
    input  logic [srb_pkg::SEQ_W-1:0] i_seq_no,
    input  logic [srb_pkg::TAG_W-1:0] i_tag,
    output logic                      o_strobe,
    output logic                      o_released,
    output logic [srb_pkg::TAG_W-1:0] o_out_tag,
    output logic [srb_pkg::SEQ_W-1:0] o_out_seq_no,
    output logic                      o_last,
    output logic [1:0]                o_status
);

    localparam int unsigned HW    = $clog2(WINDOW);
    localparam int unsigned CW    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int unsigned SLOTS = CONTEXTS * WINDOW;
    localparam int unsigned AW    = $clog2(SLOTS);

    // captured word
    logic                      r_dir;
    logic [srb_pkg::SEQ_W-1:0] r_seq;
    logic [srb_pkg::TAG_W-1:0] r_tag;

    logic [srb_pkg::SEQ_W-1:0] r_next_exp [CONTEXTS];
    logic [HW-1:0]             r_head     [CONTEXTS];
    logic [SLOTS-1:0]          r_valid;
    logic [srb_pkg::TAG_W-1:0] r_mem      [SLOTS];
    logic [srb_pkg::TAG_W-1:0] r_rd_tag;

    logic                      r_stb;
    logic                      r_released;
    logic [srb_pkg::TAG_W-1:0] r_otag;
    logic [srb_pkg::SEQ_W-1:0] r_oseq;
    logic                      r_last;
    srb_pkg::t_status          r_status;

    logic                      ctx_ok;
    logic [CW-1:0]             ctx;
    logic [srb_pkg::SEQ_W-1:0] exp_no;
    logic [HW-1:0]             head;
    logic [srb_pkg::SEQ_W-1:0] diff;
    logic [HW:0]               park_sum;
    logic [HW-1:0]             park_slot;
    logic [HW-1:0]             nxt_head;
    logic [AW-1:0]             base;
    logic [AW-1:0]             cur_addr;
    logic [AW-1:0]             nxt_addr;
    logic [AW-1:0]             park_addr;
    srb_pkg::t_status          err_code;

    always_comb begin
        ctx_ok    = (CONTEXTS > 1) || (r_dir == 1'b0);
        ctx       = ctx_ok ? CW'(r_dir) : '0;
        exp_no    = r_next_exp[ctx];
        head      = r_head[ctx];
        diff      = r_seq - exp_no;
        base      = AW'(ctx) * AW'(WINDOW);
        park_sum  = {1'b0, head} + {1'b0, diff[HW-1:0]};
        park_slot = (park_sum >= (HW+1)'(WINDOW)) ? HW'(park_sum - (HW+1)'(WINDOW))
                                                  : park_sum[HW-1:0];
        nxt_head  = (head == HW'(WINDOW - 1)) ? '0 : head + HW'(1);
        cur_addr  = base + AW'(head);
        nxt_addr  = base + AW'(nxt_head);
        park_addr = base + AW'(park_slot);
    end

    // classification of the captured word
    always_comb begin
        o_stat.cls  = srb_pkg::CLS_ERROR;
        o_stat.more = r_valid[nxt_addr];
        err_code    = srb_pkg::ST_BEYOND;
        priority if (!ctx_ok) begin
            err_code = srb_pkg::ST_BEYOND;
        end else if (diff == '0) begin
            o_stat.cls = srb_pkg::CLS_INORDER;
        end else if (diff[srb_pkg::SEQ_W-1]) begin
            err_code = srb_pkg::ST_STALE;
        end else if (diff >= srb_pkg::SEQ_W'(WINDOW)) begin
            err_code = srb_pkg::ST_BEYOND;
        end else if (r_valid[park_addr]) begin
            err_code = srb_pkg::ST_DUP;
        end else begin
            o_stat.cls = srb_pkg::CLS_PARK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_dir <= i_direction;
            r_seq <= i_seq_no;
            r_tag <= i_tag;
        end
    end

    // context state; a register write restarts every context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            for (int c = 0; c < CONTEXTS; c++) begin
                r_next_exp[c] <= i_rst_n ? i_cfg_wdata : '0;
                r_head[c]     <= '0;
            end
            r_valid <= '0;
        end else begin
            if (i_cmd.park) r_valid[park_addr] <= 1'b1;
            if (i_cmd.rel_drain) r_valid[cur_addr] <= 1'b0;
            if (i_cmd.rel_first || i_cmd.rel_drain) begin
                r_next_exp[ctx] <= exp_no + srb_pkg::SEQ_W'(1);
                r_head[ctx]     <= nxt_head;
            end
        end
    end

    // tag store, registered read of the slot after the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.park) r_mem[park_addr] <= r_tag;
        r_rd_tag <= r_mem[nxt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stb <= 1'b0;
        end else begin
            r_stb <= i_cmd.emit_err | i_cmd.rel_first | i_cmd.rel_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_released <= 1'b0;
            r_otag     <= r_tag;
            r_oseq     <= r_seq;
            r_last     <= 1'b1;
            r_status   <= err_code;
        end else if (i_cmd.rel_first) begin
            r_released <= 1'b1;
            r_otag     <= r_tag;
            r_oseq     <= r_seq;
            r_last     <= !r_valid[nxt_addr];
            r_status   <= srb_pkg::ST_OK;
        end else if (i_cmd.rel_drain) begin
            r_released <= 1'b1;
            r_otag     <= r_rd_tag;
            r_oseq     <= exp_no;
            r_last     <= !r_valid[nxt_addr];
            r_status   <= srb_pkg::ST_OK;
        end
    end

    assign o_strobe     = r_stb;
    assign o_released   = r_released;
    assign o_out_tag    = r_otag;
    assign o_out_seq_no = r_oseq;
    assign o_last       = r_last;
    assign o_status     = r_status;

    // a result without last is always followed by another one
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stb && !r_last |=> r_stb)
        else $error("release run broken before last");

    // drain only releases a slot that holds a parked word
    a_drain_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rel_drain |-> r_valid[cur_addr])
        else $error("drain of an empty slot");

    // a parked word always belongs ahead of the expected number
    a_park_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.park |-> (diff != '0) && !diff[srb_pkg::SEQ_W-1])
        else $error("park outside the window");

endmodule

// ===== sim/tb_sequence_reorder_buffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequence_reorder_buffer_top: self-checking bench for the reorder buffer
// Feeds segments per direction and predicts the released and error words in
// order. Directed cases cover the first in-order word, a full-window drain,
// every error class and wrap of the sequence space. Random traffic follows:
// shuffled in-window bursts mixed with stale, duplicate and far segments,
// under several start numbers.
// ----------------------------------------------------------------------------
module tb_sequence_reorder_buffer_top;

    localparam int unsigned WINDOW      = 16;
    localparam int unsigned CONTEXTS    = 2;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE      = 6;
    localparam int          DUE_DEPTH   = 64;
    localparam int unsigned SEQ_W       = srb_pkg::SEQ_W;
    localparam int unsigned TAG_W       = srb_pkg::TAG_W;

    // one result word as the block should present it
    typedef struct packed {
        logic             released;
        logic [TAG_W-1:0] tag;
        logic [SEQ_W-1:0] seq;
        logic             last;
        srb_pkg::t_status status;
    } t_release_word;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_cfg_we = 1'b0;
    logic [SEQ_W-1:0] i_cfg_wdata = '0;
    logic             i_direction = 1'b0;
    logic [SEQ_W-1:0] i_seq_no = '0;
    logic [TAG_W-1:0] i_tag = '0;
    logic             o_strobe;
    logic             o_released;
    logic [TAG_W-1:0] o_out_tag;
    logic [SEQ_W-1:0] o_out_seq_no;
    logic             o_last;
    logic [1:0]       o_status;

    sequence_reorder_buffer_top #(
        .WINDOW   (WINDOW),
        .CONTEXTS (CONTEXTS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_direction  (i_direction),
        .i_seq_no     (i_seq_no),
        .i_tag        (i_tag),
        .o_strobe     (o_strobe),
        .o_released   (o_released),
        .o_out_tag    (o_out_tag),
        .o_out_seq_no (o_out_seq_no),
        .o_last       (o_last),
        .o_status     (o_status)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Ordering state mirrored from the block
    // ------------------------------------------------------------------
    logic [SEQ_W-1:0] next_seq [CONTEXTS];
    int unsigned      head_slot [CONTEXTS];
    logic             slot_valid [CONTEXTS*WINDOW];
    logic [TAG_W-1:0] slot_tag [CONTEXTS*WINDOW];

    // due words, oldest at due_rd
    t_release_word    due_ring [DUE_DEPTH];
    int               due_rd = 0;
    int               due_wr = 0;

    int  sent_count     = 0;
    int  word_count     = 0;
    int  parked_count   = 0;
    int  error_count    = 0;
    int  drain_max      = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  checking       = 1'b0;
    bit  no_idle        = 1'b0;

    // random burst bookkeeping per direction
    logic [SEQ_W-1:0] burst_seq [CONTEXTS][WINDOW];
    int               burst_len [CONTEXTS];

    function automatic int due_size();
        return due_wr - due_rd;
    endfunction

    function automatic void restart_order(input logic [SEQ_W-1:0] value);
        for (int c = 0; c < CONTEXTS; c++) begin
            next_seq[c]  = value;
            head_slot[c] = 0;
            burst_len[c] = 0;
        end
        for (int s = 0; s < CONTEXTS*WINDOW; s++) begin
            slot_valid[s] = 1'b0;
        end
    endfunction

    function automatic void push_word(input logic rel, input logic [TAG_W-1:0] tg,
                                      input logic [SEQ_W-1:0] seq, input logic lst,
                                      input srb_pkg::t_status st);
        t_release_word w;
        w.released = rel;
        w.tag      = tg;
        w.seq      = seq;
        w.last     = lst;
        w.status   = st;
        due_ring[due_wr % DUE_DEPTH] = w;
        due_wr++;
    endfunction

    // Classify one accepted segment and queue the words it releases.
    function automatic void order_segment(input logic d, input logic [SEQ_W-1:0] seq,
                                          input logic [TAG_W-1:0] tg);
        logic [SEQ_W-1:0] diff;
        logic [TAG_W-1:0] run_tag [WINDOW];
        logic [SEQ_W-1:0] run_seq [WINDOW];
        int               base;
        int               slot;
        int               n;
        base = int'(d) * WINDOW;
        diff = seq - next_seq[d];
        if (diff != 0) begin
            error_count++;
            if (diff[SEQ_W-1]) begin
                push_word(1'b0, tg, seq, 1'b1, srb_pkg::ST_STALE);
            end else if (diff >= WINDOW) begin
                push_word(1'b0, tg, seq, 1'b1, srb_pkg::ST_BEYOND);
            end else begin
                slot = base + int'((head_slot[d] + diff) % WINDOW);
                if (slot_valid[slot]) begin
                    push_word(1'b0, tg, seq, 1'b1, srb_pkg::ST_DUP);
                end else begin
                    error_count--;
                    parked_count++;
                    slot_valid[slot] = 1'b1;
                    slot_tag[slot]   = tg;
                end
            end
            return;
        end
        // in order: the arrival, then the run of parked slots behind it
        run_tag[0]   = tg;
        run_seq[0]   = seq;
        n            = 1;
        next_seq[d]  = next_seq[d] + 1;
        head_slot[d] = (head_slot[d] + 1) % WINDOW;
        for (int i = 1; i < WINDOW; i++) begin
            slot = base + int'(head_slot[d]);
            if (!slot_valid[slot]) break;
            run_tag[n]       = slot_tag[slot];
            run_seq[n]       = next_seq[d];
            n++;
            slot_valid[slot] = 1'b0;
            next_seq[d]      = next_seq[d] + 1;
            head_slot[d]     = (head_slot[d] + 1) % WINDOW;
        end
        if (n > drain_max) drain_max = n;
        for (int k = 0; k < n; k++) begin
            push_word(1'b1, run_tag[k], run_seq[k], k == n - 1, srb_pkg::ST_OK);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result check: every strobed word against the oldest due word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_words
        t_release_word want;
        if (checking && o_strobe === 1'b1) begin
            word_count++;
            if (due_size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: released %0b tag %h seq %h last %0b status %0d",
                             o_released, o_out_tag, o_out_seq_no, o_last, o_status);
            end else begin
                want = due_ring[due_rd % DUE_DEPTH];
                due_rd++;
                if (o_released !== want.released || o_out_tag !== want.tag ||
                    o_out_seq_no !== want.seq || o_last !== want.last ||
                    o_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("mismatch at word %0d (exp/got): released %0b/%0b tag %h/%h ",
                               word_count, want.released, o_released, want.tag, o_out_tag);
                        $display("seq %h/%h last %0b/%0b status %0d/%0d",
                                 want.seq, o_out_seq_no, want.last, o_last,
                                 want.status, o_status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, due_size());
            $display("[sequence_reorder_buffer_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drive helpers
    // ------------------------------------------------------------------
    task automatic send_segment(input logic d, input logic [SEQ_W-1:0] seq,
                                input logic [TAG_W-1:0] tg);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       = 1'b1;
        i_direction = d;
        i_seq_no    = seq;
        i_tag       = tg;
        do @(posedge i_clk); while (busy !== 1'b0);
        order_segment(d, seq, tg);
        sent_count++;
    endtask

    // Hold off until every due word is out; parked words give none, so
    // let the bench settle and wait for busy low before calling it idle.
    task automatic wait_all_released;
        @(negedge i_clk);
        start = 1'b0;
        while (due_size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_start_seq(input logic [SEQ_W-1:0] value);
        wait_all_released();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        restart_order(value);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_first_in_order;
        send_segment(1'b0, 32'h0000_0000, 16'h0000);
        send_segment(1'b1, 32'h0000_0000, 16'hFFFF);
    endtask

    // Fill the whole window behind the head, try a duplicate, then release
    // all of it with one in-order segment.
    task automatic test_full_window_drain;
        write_start_seq(32'h0000_0000);
        for (int off = WINDOW - 1; off >= 1; off--) begin
            send_segment(1'b0, SEQ_W'(off), TAG_W'(16'hA500 + off));
        end
        send_segment(1'b0, 32'd5, 16'h5A5A);
        send_segment(1'b0, 32'd0, 16'hFFFF);
    endtask

    task automatic test_error_classes;
        send_segment(1'b1, 32'hFFFF_FFFF, 16'h0001);
        send_segment(1'b1, 32'h8000_0000, 16'h0002);
        send_segment(1'b1, SEQ_W'(WINDOW), 16'h0003);
        send_segment(1'b1, 32'h7FFF_FFFF, 16'h0004);
    endtask

    task automatic test_sequence_wrap;
        write_start_seq(32'hFFFF_FFFF);
        send_segment(1'b0, 32'h0000_0001, 16'h8001);
        send_segment(1'b0, 32'hFFFF_FFFF, 16'h8000);
        send_segment(1'b0, 32'h0000_0000, 16'h7FFF);
    endtask

    task automatic test_random_traffic(input logic [SEQ_W-1:0] first_seq,
                                       input int count);
        logic             d;
        logic [SEQ_W-1:0] seq;
        int               idx;
        int               len;
        write_start_seq(first_seq);
        for (int k = 0; k < count; k++) begin
            no_idle = ((k / 40) % 3) == 0;
            if (k > 0 && k % 60 == 0) wait_all_released();
            d = 1'($urandom_range(0, CONTEXTS - 1));
            if ($urandom_range(0, 99) < 15) begin
                // noise: late, far, repeated or arbitrary numbers
                case ($urandom_range(0, 4))
                    0: seq = next_seq[d] - SEQ_W'($urandom_range(1, 64));
                    1: seq = next_seq[d] + 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
                    2: seq = next_seq[d] + $urandom_range(WINDOW, 32'h7FFF_FFFF);
                    3: seq = next_seq[d] + SEQ_W'($urandom_range(1, WINDOW - 1));
                    default: seq = $urandom;
                endcase
            end else begin
                if (burst_len[d] == 0) begin
                    len = $urandom_range(1, WINDOW);
                    for (int j = 0; j < len; j++) burst_seq[d][j] = next_seq[d] + SEQ_W'(j);
                    burst_len[d] = len;
                end
                idx = $urandom_range(0, burst_len[d] - 1);
                seq = burst_seq[d][idx];
                burst_seq[d][idx] = burst_seq[d][burst_len[d] - 1];
                burst_len[d]--;
            end
            send_segment(d, seq, TAG_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial begin
        restart_order('0);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        checking = 1'b1;

        test_first_in_order();
        test_full_window_drain();
        test_error_classes();
        test_sequence_wrap();

        test_random_traffic(32'h0000_0000, 100);
        test_random_traffic(32'hFFFF_FFF0, 100);
        test_random_traffic(32'h7FFF_FFF8, 100);
        test_random_traffic($urandom, 100);
        test_random_traffic(32'hFFFF_FFFF, 100);

        wait_all_released();
        if (due_size() != 0) begin
            mismatch_count++;
            $display("%0d words never arrived", due_size());
        end

        $display("Run covered %0d segments: %0d words checked, %0d parked, %0d error words.",
                 sent_count, word_count, parked_count, error_count);
        $display("Longest in-order run released by one segment: %0d words.", drain_max);
        if (mismatch_count == 0) begin
            $display("[sequence_reorder_buffer_top] OK");
        end else begin
            $display("%0d failures", mismatch_count);
            $display("[sequence_reorder_buffer_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/srb_pkg.sv
rtl/srb_ctrl.sv
rtl/srb_dpath.sv
rtl/sequence_reorder_buffer_top.sv
sim/tb_sequence_reorder_buffer_top.sv
